>>> rtl/vfac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfac_pkg
// shared types, frame characters and the precomputed angle-step tables
// ----------------------------------------------------------------------------
package vfac_pkg;

    localparam int WIN_LEN    = 11;
    localparam int TENTHS_W   = 13;
    localparam int ANGLE_W    = 32;
    localparam int DELTA_W    = 16;
    localparam int TAB_LEN    = 199;
    localparam int TAB_OFFSET = 99;
    localparam int TAB_IDX_W  = $clog2(TAB_LEN);

    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_E     = 8'h65;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam longint YAW_FAR_SCALE  = 65536;
    localparam longint YAW_FAR_DIV    = 1200;
    localparam longint YAW_NEAR_SCALE = 6225920;
    localparam longint YAW_NEAR_DIV   = 120000;
    localparam longint PITCH_SCALE    = 65536;
    localparam longint PITCH_DIV      = 2000;
    localparam int     YAW_NEAR_LIM   = 75;
    localparam int     YAW_NEAR_BIAS  = 2;

    typedef logic signed [TENTHS_W-1:0] tenths_t;
    typedef logic signed [ANGLE_W-1:0]  angle_t;
    typedef logic signed [DELTA_W-1:0]  delta_t;
    typedef delta_t [TAB_LEN-1:0]       delta_tab_t;

    typedef struct packed {
        logic   yaw_update;
        angle_t yaw_target;
        logic   pitch_update;
        angle_t pitch_target;
        logic   shoot;
    } aim_result_t;

    // yaw step per held tenth, rounded to nearest, ties away from zero
    function automatic delta_tab_t build_yaw_tab();
        delta_tab_t tab;
        longint     n;
        longint     q;
        int         t;
        tab = '0;
        for (int i = 0; i < TAB_LEN; i++)
        begin
            t = i - TAB_OFFSET;
            if (t > YAW_NEAR_LIM || t < -YAW_NEAR_LIM)
            begin
                n = longint'(t) * YAW_FAR_SCALE;
                q = (n >= 0) ? (n + YAW_FAR_DIV / 2) / YAW_FAR_DIV
                             : -((-n + YAW_FAR_DIV / 2) / YAW_FAR_DIV);
            end
            else
            begin
                n = longint'(t - YAW_NEAR_BIAS) * YAW_NEAR_SCALE;
                q = (n >= 0) ? (n + YAW_NEAR_DIV / 2) / YAW_NEAR_DIV
                             : -((-n + YAW_NEAR_DIV / 2) / YAW_NEAR_DIV);
            end
            tab[i] = DELTA_W'(q);
        end
        return tab;
    endfunction

    // pitch step per held tenth, rounded to nearest, ties away from zero
    function automatic delta_tab_t build_pitch_tab();
        delta_tab_t tab;
        longint     n;
        longint     q;
        tab = '0;
        for (int i = 0; i < TAB_LEN; i++)
        begin
            n = longint'(i - TAB_OFFSET) * PITCH_SCALE;
            q = (n >= 0) ? (n + PITCH_DIV / 2) / PITCH_DIV
                         : -((-n + PITCH_DIV / 2) / PITCH_DIV);
            tab[i] = DELTA_W'(q);
        end
        return tab;
    endfunction

    localparam delta_tab_t YAW_TAB   = build_yaw_tab();
    localparam delta_tab_t PITCH_TAB = build_pitch_tab();

    // signed tenths from sign, units and tenths characters
    function automatic tenths_t decode_tenths(input logic [7:0] sign_c,
                                              input logic [7:0] units_c,
                                              input logic [7:0] tenths_c);
        tenths_t ud;
        tenths_t td;
        tenths_t v;
        ud = tenths_t'({5'b0, units_c}) - tenths_t'({5'b0, CHAR_ZERO});
        td = tenths_t'({5'b0, tenths_c}) - tenths_t'({5'b0, CHAR_ZERO});
        v  = ud * tenths_t'(10) + td;
        return (sign_c == CHAR_MINUS) ? -v : v;
    endfunction

endpackage

>>> rtl/vfac_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfac_frame
// byte window shift register and frame decode into held pitch/yaw tenths
// ----------------------------------------------------------------------------
module vfac_frame
    import vfac_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift_en,
    input  logic [7:0] rx_byte,
    output tenths_t    held_yaw,
    output tenths_t    held_pitch
);

    logic [WIN_LEN-1:0][7:0] win_reg;
    logic [WIN_LEN-1:0][7:0] win_next;
    tenths_t                 yaw_reg;
    tenths_t                 pitch_reg;
    logic                    frame_hit;

    always_comb
    begin
        for (int i = 0; i < WIN_LEN - 1; i++)
        begin
            win_next[i] = win_reg[i + 1];
        end
        win_next[WIN_LEN - 1] = rx_byte;
    end

    assign frame_hit = (win_next[0] == CHAR_A) && (win_next[WIN_LEN - 1] == CHAR_E);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= '0;
            yaw_reg   <= '0;
            pitch_reg <= '0;
        end
        else if (shift_en)
        begin
            win_reg <= win_next;
            if (frame_hit)
            begin
                pitch_reg <= decode_tenths(win_next[1], win_next[2], win_next[4]);
                yaw_reg   <= decode_tenths(win_next[6], win_next[7], win_next[9]);
            end
        end
    end

    assign held_yaw   = yaw_reg;
    assign held_pitch = pitch_reg;

endmodule

>>> rtl/vfac_aim.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfac_aim
// target angles and shoot flag from held tenths and current angles
// ----------------------------------------------------------------------------
module vfac_aim
    import vfac_pkg::*;
(
    input  tenths_t     held_yaw,
    input  tenths_t     held_pitch,
    input  angle_t      yaw_now,
    input  angle_t      pitch_now,
    output aim_result_t res
);

    logic [TENTHS_W-1:0]  yaw_mag;
    logic [TENTHS_W-1:0]  pitch_mag;
    logic signed [TENTHS_W:0] yaw_err;
    logic [TENTHS_W:0]    yaw_err_mag;
    logic [TAB_IDX_W-1:0] yaw_idx;
    logic [TAB_IDX_W-1:0] pitch_idx;
    logic                 yaw_ok;
    logic                 pitch_ok;
    angle_t               yaw_step;
    angle_t               pitch_step;

    assign yaw_mag   = held_yaw[TENTHS_W-1] ? TENTHS_W'(-held_yaw) : TENTHS_W'(held_yaw);
    assign pitch_mag = held_pitch[TENTHS_W-1] ? TENTHS_W'(-held_pitch)
                                              : TENTHS_W'(held_pitch);

    assign yaw_ok   = (yaw_mag > TENTHS_W'(1)) && (yaw_mag < TENTHS_W'(100));
    assign pitch_ok = (pitch_mag > TENTHS_W'(1)) && (pitch_mag < TENTHS_W'(100));

    // table row is tenths plus offset, valid only inside the update window
    assign yaw_idx   = held_yaw[TAB_IDX_W-1:0] + TAB_IDX_W'(TAB_OFFSET);
    assign pitch_idx = held_pitch[TAB_IDX_W-1:0] + TAB_IDX_W'(TAB_OFFSET);

    assign yaw_step   = ANGLE_W'(YAW_TAB[yaw_idx]);
    assign pitch_step = ANGLE_W'(PITCH_TAB[pitch_idx]);

    assign yaw_err     = {held_yaw[TENTHS_W-1], held_yaw} - (TENTHS_W+1)'(2);
    assign yaw_err_mag = yaw_err[TENTHS_W] ? (TENTHS_W+1)'(-yaw_err) : (TENTHS_W+1)'(yaw_err);

    always_comb
    begin
        res.yaw_update   = yaw_ok;
        res.yaw_target   = yaw_ok ? (yaw_now + yaw_step) : '0;
        res.pitch_update = pitch_ok;
        res.pitch_target = pitch_ok ? (pitch_now - pitch_step) : '0;
        res.shoot        = (yaw_err_mag < (TENTHS_W+1)'(20)) && (pitch_mag < TENTHS_W'(21));
    end

endmodule

>>> rtl/vision_frame_aim_correction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vision_frame_aim_correction
// frame byte decoder and aim target generator with valid/stall channels
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------
//   in      | in        | in_valid / in_stall   | command, rx_byte, yaw_now,
//           |           |                       | pitch_now
//   out     | out       | out_valid / out_stall | yaw_update, yaw_target,
//           |           |                       | pitch_update, pitch_target,
//           |           |                       | shoot
//
// one item per cycle while no result is stalled; a tick's result passes
// through the input register and the result register, around the table
// lookups, and leaves when out_stall is low
// reset clears the byte window, held tenths and all valid flags
// bytes never wait on the output; a tick waits in the input register while a
// result is stalled, and in_stall rises only then
// ----------------------------------------------------------------------------
module vision_frame_aim_correction
    import vfac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [7:0]  rx_byte,
    input  angle_t      yaw_now,
    input  angle_t      pitch_now,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        yaw_update,
    output angle_t      yaw_target,
    output logic        pitch_update,
    output angle_t      pitch_target,
    output logic        shoot
);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        s1_command_reg;
    logic [7:0]  s1_byte_reg;
    angle_t      s1_yaw_reg;
    angle_t      s1_pitch_reg;
    logic        s1_load;
    logic        s1_adv;
    logic        shift_en;
    logic        out_load;
    logic        out_valid_reg;
    logic        out_valid_next;
    aim_result_t out_res_reg;
    aim_result_t aim_res;
    tenths_t     held_yaw;
    tenths_t     held_pitch;

    // a tick holds only while the result register is full and stalled
    assign s1_adv   = !((s1_command_reg == CMD_TICK) && out_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign s1_load  = in_valid && !in_stall;
    assign shift_en = s1_valid_reg && (s1_command_reg == CMD_BYTE);
    assign out_load = s1_valid_reg && (s1_command_reg == CMD_TICK) && s1_adv;

    always_comb
    begin
        priority if (s1_load)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_comb
    begin
        priority if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_command_reg <= command;
            s1_byte_reg    <= rx_byte;
            s1_yaw_reg     <= yaw_now;
            s1_pitch_reg   <= pitch_now;
        end
        if (out_load)
        begin
            out_res_reg <= aim_res;
        end
    end

    vfac_frame u_frame (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift_en   (shift_en),
        .rx_byte    (s1_byte_reg),
        .held_yaw   (held_yaw),
        .held_pitch (held_pitch)
    );

    vfac_aim u_aim (
        .held_yaw   (held_yaw),
        .held_pitch (held_pitch),
        .yaw_now    (s1_yaw_reg),
        .pitch_now  (s1_pitch_reg),
        .res        (aim_res)
    );

    assign out_valid    = out_valid_reg;
    assign yaw_update   = out_res_reg.yaw_update;
    assign yaw_target   = out_res_reg.yaw_target;
    assign pitch_update = out_res_reg.pitch_update;
    assign pitch_target = out_res_reg.pitch_target;
    assign shoot        = out_res_reg.shoot;

endmodule

>>> rtl/vfac_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfac_checker
// port-level checks on the result channel and on in_stall of the aim correction block
// ----------------------------------------------------------------------------
module vfac_checker
    import vfac_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       yaw_update,
    input angle_t     yaw_target,
    input logic       pitch_update,
    input angle_t     pitch_target,
    input logic       shoot
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(yaw_target)
            && $stable(pitch_target) && $stable(shoot))
        else $error("result changed while stalled");

    // no update means a zero target
    a_yaw_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !yaw_update |-> yaw_target == '0)
        else $error("yaw target not zero without update");

    a_pitch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pitch_update |-> pitch_target == '0)
        else $error("pitch target not zero without update");

    // input side only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");

endmodule

bind vision_frame_aim_correction vfac_checker u_vfac_checker (.*);

>>> dv/vfac_aim_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfac_aim_checker
// Watches both channels of the aim correction block. It keeps its own byte
// window and held tenths, predicts one aim result for every tick transfer
// and compares every output transfer field by field with the oldest one due.
// Hands a mismatch count and the number of results still due to the top.
// ----------------------------------------------------------------------------
module vfac_aim_checker
    import vfac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        command,
    input  logic [7:0]  rx_byte,
    input  angle_t      yaw_now,
    input  angle_t      pitch_now,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        yaw_update,
    input  angle_t      yaw_target,
    input  logic        pitch_update,
    input  angle_t      pitch_target,
    input  logic        shoot,
    output int          mismatches,
    output int          pending
);

    localparam longint Q_ONE         = 65536;
    localparam longint YAW_FAR_DEN   = 1200;
    localparam longint YAW_NEAR_NUM  = 6225920;
    localparam longint YAW_NEAR_DEN  = 120000;
    localparam longint PITCH_DEN     = 2000;
    localparam int     NEAR_LIMIT    = 75;
    localparam int     NEAR_BIAS     = 2;
    localparam int     STEP_LIMIT    = 100;
    localparam int     AIM_YAW_WIN   = 20;
    localparam int     AIM_PITCH_WIN = 21;
    localparam int     REPORT_MAX    = 10;

    logic [7:0]  window [WIN_LEN];
    tenths_t     held_yaw;
    tenths_t     held_pitch;
    aim_result_t aim_due [$];
    aim_result_t aim_seen;
    aim_result_t aim_want;
    int          miss_count = 0;

    initial
    begin
        mismatches = 0;
        pending    = 0;
    end

    // nearest integer, halves away from zero
    function automatic longint div_round(input longint n, input longint d);
        if (n >= 0)
            return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic tenths_t frame_tenths(input logic [7:0] sign_c,
                                             input logic [7:0] units_c,
                                             input logic [7:0] tenths_c);
        int v;
        v = 10 * (int'(units_c) - int'(CHAR_ZERO)) + (int'(tenths_c) - int'(CHAR_ZERO));
        if (sign_c == CHAR_MINUS)
            v = -v;
        return tenths_t'(v);
    endfunction

    function automatic aim_result_t predict_aim(input angle_t yaw_in, input angle_t pitch_in);
        aim_result_t r;
        int          t;
        int          p;
        int          at;
        int          ap;
        int          aim_err;
        longint      step;
        r       = '0;
        t       = held_yaw;
        p       = held_pitch;
        at      = (t < 0) ? -t : t;
        ap      = (p < 0) ? -p : p;
        aim_err = (t - NEAR_BIAS < 0) ? NEAR_BIAS - t : t - NEAR_BIAS;
        if (at > 1 && at < STEP_LIMIT)
        begin
            if (at > NEAR_LIMIT)
                step = div_round(longint'(t) * Q_ONE, YAW_FAR_DEN);
            else
                step = div_round(longint'(t - NEAR_BIAS) * YAW_NEAR_NUM, YAW_NEAR_DEN);
            r.yaw_update = 1'b1;
            r.yaw_target = angle_t'(longint'(yaw_in) + step);
        end
        if (ap > 1 && ap < STEP_LIMIT)
        begin
            step           = div_round(longint'(p) * Q_ONE, PITCH_DEN);
            r.pitch_update = 1'b1;
            r.pitch_target = angle_t'(longint'(pitch_in) - step);
        end
        r.shoot = (aim_err < AIM_YAW_WIN) && (ap < AIM_PITCH_WIN);
        return r;
    endfunction

    task automatic note_miss(input string what, input aim_result_t want, input aim_result_t got);
        miss_count++;
        if (miss_count <= REPORT_MAX)
            $display({"%0t: %s: expected yaw %0b/%0d pitch %0b/%0d shoot %0b, ",
                      "actual yaw %0b/%0d pitch %0b/%0d shoot %0b"},
                     $time, what, want.yaw_update, want.yaw_target, want.pitch_update,
                     want.pitch_target, want.shoot, got.yaw_update, got.yaw_target,
                     got.pitch_update, got.pitch_target, got.shoot);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (window[i])
                window[i] = '0;
            held_yaw   = '0;
            held_pitch = '0;
            aim_due.delete();
            pending    <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                aim_seen = '{yaw_update, yaw_target, pitch_update, pitch_target, shoot};
                if (aim_due.size() == 0)
                    note_miss("result transfer with nothing due", '0, aim_seen);
                else
                begin
                    aim_want = aim_due.pop_front();
                    if (aim_seen.yaw_update !== aim_want.yaw_update
                        || aim_seen.yaw_target !== aim_want.yaw_target
                        || aim_seen.pitch_update !== aim_want.pitch_update
                        || aim_seen.pitch_target !== aim_want.pitch_target
                        || aim_seen.shoot !== aim_want.shoot)
                        note_miss("result mismatch", aim_want, aim_seen);
                end
            end
            if (in_valid && !in_stall)
            begin
                if (command == CMD_TICK)
                    aim_due.push_back(predict_aim(yaw_now, pitch_now));
                else
                begin
                    for (int i = 0; i < WIN_LEN - 1; i++)
                        window[i] = window[i + 1];
                    window[WIN_LEN - 1] = rx_byte;
                    if (window[0] == CHAR_A && window[WIN_LEN - 1] == CHAR_E)
                    begin
                        held_pitch = frame_tenths(window[1], window[2], window[4]);
                        held_yaw   = frame_tenths(window[6], window[7], window[9]);
                    end
                end
            end
            pending <= aim_due.size();
        end
        mismatches <= miss_count;
    end

endmodule

>>> dv/vision_frame_aim_correction_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vision_frame_aim_correction_tb
// Drives frame bytes and control ticks into the aim correction block: a few
// hand-built frames first, then mostly well-formed frames with random and
// boundary offsets mixed with noise and cut frames, random angles and
// random idling on both channels. The checker beside the block predicts
// and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module vision_frame_aim_correction_tb;
    import vfac_pkg::*;

    localparam int TOTAL_ITEMS  = 1050;
    localparam int CALM_FROM    = 300;
    localparam int CALM_TO      = 520;
    localparam int DRAIN_AT     = 650;
    localparam int SETTLE_WAIT  = 8;
    localparam int CYCLE_LIMIT  = 200000;

    typedef logic [7:0] frame_t [WIN_LEN];

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic        command      = CMD_BYTE;
    logic [7:0]  rx_byte      = '0;
    angle_t      yaw_now      = '0;
    angle_t      pitch_now    = '0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic        yaw_update;
    angle_t      yaw_target;
    logic        pitch_update;
    angle_t      pitch_target;
    logic        shoot;
    logic        calm         = 1'b0;
    int          mismatches;
    int          pending;
    int          sent         = 0;
    int          cycles       = 0;

    always #5 clk = ~clk;

    vision_frame_aim_correction DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .rx_byte      (rx_byte),
        .yaw_now      (yaw_now),
        .pitch_now    (pitch_now),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .yaw_update   (yaw_update),
        .yaw_target   (yaw_target),
        .pitch_update (pitch_update),
        .pitch_target (pitch_target),
        .shoot        (shoot)
    );

    vfac_aim_checker aim_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .rx_byte      (rx_byte),
        .yaw_now      (yaw_now),
        .pitch_now    (pitch_now),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .yaw_update   (yaw_update),
        .yaw_target   (yaw_target),
        .pitch_update (pitch_update),
        .pitch_target (pitch_target),
        .shoot        (shoot),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < 9);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send(input logic cmd, input logic [7:0] b, input angle_t yaw,
                        input angle_t pitch);
        bit quiet;
        bit taken;
        quiet = (sent >= CALM_FROM && sent < CALM_TO);
        calm <= quiet;
        while (!quiet && $urandom_range(99) < 9)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        rx_byte   <= b;
        yaw_now   <= yaw;
        pitch_now <= pitch;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        sent++;
    endtask

    function automatic angle_t random_angle();
        case ($urandom_range(9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        send(CMD_BYTE, b, $urandom, $urandom);
    endtask

    task automatic send_tick(input angle_t yaw, input angle_t pitch);
        send(CMD_TICK, 8'($urandom_range(255)), yaw, pitch);
    endtask

    task automatic send_frame(input frame_t f, input int count);
        for (int i = 0; i < count; i++)
            send_byte(f[i]);
    endtask

    function automatic logic [7:0] filler();
        case ($urandom_range(3))
            0: return ",";
            1: return ".";
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic frame_t frame_of(input logic [7:0] ps, input logic [7:0] pu,
                                        input logic [7:0] pd, input logic [7:0] ys,
                                        input logic [7:0] yu, input logic [7:0] yd);
        frame_t f;
        f = '{CHAR_A, ps, pu, filler(), pd, filler(), ys, yu, filler(), yd, CHAR_E};
        return f;
    endfunction

    // sign and two digit characters, leaning on the step and firing boundaries
    task automatic pick_offset(output logic [7:0] s, output logic [7:0] u,
                               output logic [7:0] d);
        int edges [15] = '{0, 1, 2, 3, 17, 18, 19, 20, 21, 22, 23, 75, 76, 77, 99};
        int v;
        int r;
        r = $urandom_range(99);
        if (r < 40)
            v = edges[$urandom_range(14)];
        else
            v = $urandom_range(99);
        u = CHAR_ZERO + 8'(v / 10);
        d = CHAR_ZERO + 8'(v % 10);
        if (r >= 90)
        begin
            u = 8'($urandom_range(255));
            d = 8'($urandom_range(255));
        end
        r = $urandom_range(99);
        if (r < 45)
            s = CHAR_MINUS;
        else if (r < 90)
            s = "+";
        else
            s = 8'($urandom_range(255));
    endtask

    initial
    begin
        frame_t     f;
        logic [7:0] ps;
        logic [7:0] pu;
        logic [7:0] pd;
        logic [7:0] ys;
        logic [7:0] yu;
        logic [7:0] yd;
        bit         drained;
        int         r;

        drained = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tick straight after reset, then far yaw with pitch just outside the window
        send_tick(32'sh7fffffff, 32'sh80000000);
        send_frame(frame_of(CHAR_MINUS, "2", "1", "+", "7", "6"), WIN_LEN);
        send_tick(32'sh7fffffff, 32'sh80000000);
        // non-digit pitch bytes, most negative yaw offset
        send_frame(frame_of(8'hff, 8'hff, 8'h00, CHAR_MINUS, "9", "9"), WIN_LEN);
        send_tick(32'sh80000000, 32'sh7fffffff);

        while (sent < TOTAL_ITEMS)
        begin
            pick_offset(ps, pu, pd);
            pick_offset(ys, yu, yd);
            f = frame_of(ps, pu, pd, ys, yu, yd);
            r = $urandom_range(99);
            if (r < 65)
            begin
                send_frame(f, WIN_LEN);
                repeat ($urandom_range(1, 3))
                    send_tick(random_angle(), random_angle());
            end
            else if (r < 80)
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom_range(255)));
            end
            else if (r < 92)
            begin
                if ($urandom_range(1))
                    f[WIN_LEN - 1] = 8'($urandom_range(255));
                send_frame(f, $urandom_range(1, WIN_LEN));
                send_tick(random_angle(), random_angle());
            end
            else
                send_tick(random_angle(), random_angle());

            if (!drained && sent >= DRAIN_AT)
            begin
                drained = 1'b1;
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sim.f
rtl/vfac_pkg.sv
rtl/vfac_frame.sv
rtl/vfac_aim.sv
rtl/vision_frame_aim_correction.sv
rtl/vfac_checker.sv
dv/vfac_aim_checker.sv
dv/vision_frame_aim_correction_tb.sv
